FILE: rtl/integer_matrix_multiply_accumulate_core_macros.svh
// Assertion macros for the integer matrix multiply-accumulate core.
// Used by the port checker; no other dependencies.
`ifndef INTEGER_MATRIX_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_ACCUMULATE_CORE_MACROS_SVH

// Same-cycle implication.
`define IMAC_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IMAC_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/imac_pkg.sv
`timescale 1ns / 1ps
// Shared widths, request codes and state type of the matrix multiply-accumulate core.
// No dependencies.
package imac_pkg;

    localparam int OP_W      = 3;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_C  = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_C  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

endpackage

FILE: rtl/integer_matrix_multiply_accumulate_core.sv
`timescale 1ns / 1ps
// Load requests write the A, B or C memory when taken; a read result passes the C read register and
// then the result register, held back while out_stall keeps the last result. A compute request holds
// in_stall through the i, j, k walk and the pipeline drain, one multiply-accumulate step per cycle,
// limited by the single read port of the A and B memories. Reset: asynchronous; a clearing pass
// zeroes the C memory, during which requests stall and configuration writes are still taken.
module integer_matrix_multiply_accumulate_core
    import imac_pkg::*;
#(
    parameter int MAX_DIM    = 16,
    parameter int DATA_WIDTH = 32
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OP_W-1:0]         op,
    input  logic [IDX_W-1:0]        row,
    input  logic [IDX_W-1:0]        col,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        row_res,
    output logic [IDX_W-1:0]        col_res,
    output logic signed [VAL_W-1:0] value_res
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int DW    = DATA_WIDTH;
    localparam int HW    = (DW + 1) / 2;
    localparam int LW    = DW - HW;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic nul;
    } tag_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic compute;
        logic read_c;
    } op_dec_t;

    function automatic logic [CW-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (32'(v) > MAX_DIM) begin
            return CW'(MAX_DIM);
        end
        return CW'(v);
    endfunction

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  rows_a_reg, inner_len_reg, cols_b_reg;
    logic              accumulate_reg;
    logic [CW-1:0]     n_eff, l_eff, m_eff;
    logic [CW-1:0]     i_reg, j_reg, k_reg;
    logic [AW-1:0]     clr_reg;

    logic [DW-1:0]     mem_a [DEPTH];
    logic [DW-1:0]     mem_b [DEPTH];
    logic [DW-1:0]     mem_c [DEPTH];

    tag_t              s1_reg, s2_reg, s3_reg;
    logic [AW-1:0]     s1_caddr_reg, s2_caddr_reg, s3_caddr_reg;
    logic [DW-1:0]     a_rd_reg, b_rd_reg, c_rd_reg;
    logic [DW-1:0]     s2_base_reg, s3_base_reg;
    logic [DW-1:0]     p_ll_reg;
    logic [LW-1:0]     p_lh_reg, p_hl_reg;
    logic [DW-1:0]     prod_reg, acc_reg, acc_sum;

    logic              rd_pend_reg, rd_inside_reg;
    logic [IDX_W-1:0]  rd_row_reg, rd_col_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  row_res_reg, col_res_reg;
    logic [VAL_W-1:0]  value_res_reg;

    op_dec_t           dec;
    logic              accept, in_range, issue, step_last, out_free;
    logic [AW-1:0]     addr, iss_a_addr, iss_b_addr, iss_c_addr;
    logic [DW-1:0]     val_ext;
    logic              c_we, c_re;
    logic [AW-1:0]     c_waddr, c_raddr;
    logic [DW-1:0]     c_wdata;
    logic [HW-1:0]     a_lo, b_lo;
    logic [LW-1:0]     a_hi, b_hi;

    always_comb
    begin
        dec = '0;
        unique case (op)
            OP_LOAD_A:  dec.load_a  = 1'b1;
            OP_LOAD_B:  dec.load_b  = 1'b1;
            OP_LOAD_C:  dec.load_c  = 1'b1;
            OP_COMPUTE: dec.compute = 1'b1;
            OP_READ_C:  dec.read_c  = 1'b1;
            default:    dec = '0;
        endcase
    end

    assign n_eff = eff_dim(rows_a_reg);
    assign l_eff = eff_dim(inner_len_reg);
    assign m_eff = eff_dim(cols_b_reg);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || (rd_pend_reg && !out_free);
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    assign addr     = in_range ? AW'(32'(row) * MAX_DIM + 32'(col)) : '0;
    assign val_ext  = DW'(value);

    assign issue      = (state_reg == ST_RUN);
    assign step_last  = (l_eff == '0) || (k_reg == l_eff - CW'(1));
    assign iss_a_addr = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign iss_b_addr = AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));
    assign iss_c_addr = AW'(32'(i_reg) * MAX_DIM + 32'(j_reg));

    assign a_lo = a_rd_reg[HW-1:0];
    assign a_hi = a_rd_reg[DW-1:HW];
    assign b_lo = b_rd_reg[HW-1:0];
    assign b_hi = b_rd_reg[DW-1:HW];

    assign acc_sum = (s3_reg.first ? s3_base_reg : acc_reg) + prod_reg;

    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = addr;
        c_wdata = val_ext;
        if (state_reg == ST_CLEAR)
        begin
            c_we    = 1'b1;
            c_waddr = clr_reg;
            c_wdata = '0;
        end
        else if (s3_reg.valid && s3_reg.last)
        begin
            c_we    = 1'b1;
            c_waddr = s3_caddr_reg;
            c_wdata = acc_sum;
        end
        else if (accept && dec.load_c && in_range)
        begin
            c_we = 1'b1;
        end
    end

    assign c_re    = (issue && (k_reg == '0)) || (accept && dec.read_c && in_range);
    assign c_raddr = issue ? iss_c_addr : addr;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && dec.compute && (n_eff != '0) && (m_eff != '0))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_last && (j_reg == m_eff - CW'(1)) && (i_reg == n_eff - CW'(1)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg.valid && !s2_reg.valid && !s3_reg.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rows_a_reg     <= CFG_W'(16);
            inner_len_reg  <= CFG_W'(16);
            cols_b_reg     <= CFG_W'(16);
            accumulate_reg <= 1'b0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            s3_reg         <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROWS_A:     rows_a_reg     <= cfg_data;
                    CFG_INNER_LEN:  inner_len_reg  <= cfg_data;
                    CFG_COLS_B:     cols_b_reg     <= cfg_data;
                    CFG_ACCUMULATE: accumulate_reg <= cfg_data[0];
                    default:        rows_a_reg     <= rows_a_reg;
                endcase
            end

            // Advance the i, j, k walk
            if (state_reg == ST_IDLE)
            begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end
            else if (issue)
            begin
                if (step_last)
                begin
                    k_reg <= '0;
                    if (j_reg == m_eff - CW'(1))
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + CW'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + CW'(1);
                end
            end

            s1_reg.valid <= issue;
            s1_reg.first <= (k_reg == '0);
            s1_reg.last  <= step_last;
            s1_reg.nul   <= (l_eff == '0);
            s2_reg       <= s1_reg;
            s3_reg       <= s2_reg;

            if (accept && dec.read_c)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (out_free)
            begin
                rd_pend_reg <= 1'b0;
            end

            if (rd_pend_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dec.load_a && in_range)
        begin
            mem_a[addr] <= val_ext;
        end
        if (issue)
        begin
            a_rd_reg <= mem_a[iss_a_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dec.load_b && in_range)
        begin
            mem_b[addr] <= val_ext;
        end
        if (issue)
        begin
            b_rd_reg <= mem_b[iss_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            mem_c[c_waddr] <= c_wdata;
        end
        if (c_re)
        begin
            c_rd_reg <= mem_c[c_raddr];
        end
    end

    // Multiply-accumulate datapath
    always_ff @(posedge clk)
    begin
        s1_caddr_reg <= iss_c_addr;
        s2_caddr_reg <= s1_caddr_reg;
        s3_caddr_reg <= s2_caddr_reg;
        s2_base_reg  <= accumulate_reg ? c_rd_reg : '0;
        s3_base_reg  <= s2_base_reg;
        if (s1_reg.nul)
        begin
            p_ll_reg <= '0;
            p_lh_reg <= '0;
            p_hl_reg <= '0;
        end
        else
        begin
            p_ll_reg <= DW'(a_lo) * DW'(b_lo);
            p_lh_reg <= LW'(a_lo * b_hi);
            p_hl_reg <= LW'(a_hi * b_lo);
        end
        prod_reg <= p_ll_reg + {p_lh_reg + p_hl_reg, {HW{1'b0}}};
        if (s3_reg.valid)
        begin
            acc_reg <= acc_sum;
        end
    end

    // Read result path
    always_ff @(posedge clk)
    begin
        if (accept && dec.read_c)
        begin
            rd_row_reg    <= row;
            rd_col_reg    <= col;
            rd_inside_reg <= in_range;
        end
        if (rd_pend_reg && out_free)
        begin
            row_res_reg   <= rd_row_reg;
            col_res_reg   <= rd_col_reg;
            value_res_reg <= rd_inside_reg ? VAL_W'(c_rd_reg) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_res   = row_res_reg;
    assign col_res   = col_res_reg;
    assign value_res = value_res_reg;

endmodule

FILE: rtl/imac_checker.sv
`timescale 1ns / 1ps
// Port checker for the integer matrix multiply-accumulate core, bound to the top level.
// Depends on imac_pkg and integer_matrix_multiply_accumulate_core_macros.svh.
`include "integer_matrix_multiply_accumulate_core_macros.svh"

module imac_checker
    import imac_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [OP_W-1:0]  op,
    input logic             out_valid,
    input logic             out_stall,
    input logic [IDX_W-1:0] row_res,
    input logic [IDX_W-1:0] col_res,
    input logic [VAL_W-1:0] value_res
);

    `IMAC_ASSERT_NEXT(a_reset_stalls, clk, 1'b0, !rst_n, in_stall, "request taken right after reset")

    `IMAC_ASSERT_NOW(a_result_from_read, clk, !rst_n, $rose(out_valid), $past(in_valid && !in_stall && (op == OP_READ_C), 2), "result without a read request")

    `IMAC_ASSERT_NEXT(a_out_valid_holds, clk, !rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    `IMAC_ASSERT_NEXT(a_out_payload_holds, clk, !rst_n, out_valid && out_stall, $stable(row_res) && $stable(col_res) && $stable(value_res), "result changed while stalled")

endmodule

bind integer_matrix_multiply_accumulate_core imac_checker u_imac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_res   (row_res),
    .col_res   (col_res),
    .value_res (value_res)
);

FILE: tb/sv/integer_matrix_multiply_accumulate_core_test.sv
`timescale 1ns / 1ps
// Self-checking test of the integer matrix multiply-accumulate core: loads, computes, C reads.
// Keeps its own copy of A, B, C and the sizes to predict every C read.
// Depends on imac_pkg and integer_matrix_multiply_accumulate_core.
module integer_matrix_multiply_accumulate_core_test
    import imac_pkg::*;
();

    localparam int MAX_DIM = 16;
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } mac_request_t;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } c_read_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [OP_W-1:0]         op = '0;
    logic [IDX_W-1:0]        row = '0;
    logic [IDX_W-1:0]        col = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [IDX_W-1:0]        row_res;
    logic [IDX_W-1:0]        col_res;
    logic signed [VAL_W-1:0] value_res;

    mac_request_t request_queue[$];
    c_read_t      c_reads_due[$];

    bit [VAL_W-1:0] a_copy [MAX_DIM*MAX_DIM];
    bit [VAL_W-1:0] b_copy [MAX_DIM*MAX_DIM];
    bit [VAL_W-1:0] c_copy [MAX_DIM*MAX_DIM];
    bit             a_loaded [MAX_DIM*MAX_DIM];
    bit             b_loaded [MAX_DIM*MAX_DIM];

    bit [CFG_W-1:0] cur_rows = 5'd16;
    bit [CFG_W-1:0] cur_inner = 5'd16;
    bit [CFG_W-1:0] cur_cols = 5'd16;
    bit             cur_acc = 1'b0;

    int requests_queued;
    int requests_accepted;
    int useful_items;
    int reads_checked;
    int computes_seen;
    int settings_applied;
    int mismatches;

    bit           req_taken;
    int           burst_left;
    int           gap_left;
    int           stall_left;
    int           stall_mode;
    mac_request_t next_req;
    c_read_t      due;

    integer_matrix_multiply_accumulate_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_res   (row_res),
        .col_res   (col_res),
        .value_res (value_res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: run timed out with %0d C reads outstanding", $time, c_reads_due.size());
        $display("FAIL integer_matrix_multiply_accumulate_core");
        $finish;
    end

    function automatic int eff_dim(input bit [CFG_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    task automatic mac_copy_apply(input mac_request_t req);
        int     n;
        int     l;
        int     m;
        int     addr;
        bit [VAL_W-1:0] acc;
        c_read_t rd;
        addr = {req.row, req.col};
        case (req.op)
            OP_LOAD_A: a_copy[addr] = req.value;
            OP_LOAD_B: b_copy[addr] = req.value;
            OP_LOAD_C: c_copy[addr] = req.value;
            OP_COMPUTE:
            begin
                n = eff_dim(cur_rows);
                l = eff_dim(cur_inner);
                m = eff_dim(cur_cols);
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < m; j++)
                    begin
                        acc = cur_acc ? c_copy[i*MAX_DIM + j] : '0;
                        for (int k = 0; k < l; k++)
                            acc = acc + a_copy[i*MAX_DIM + k] * b_copy[k*MAX_DIM + j];
                        c_copy[i*MAX_DIM + j] = acc;
                    end
                end
                computes_seen++;
            end
            OP_READ_C:
            begin
                rd.row = req.row;
                rd.col = req.col;
                rd.value = c_copy[addr];
                c_reads_due.push_back(rd);
            end
            default: ;
        endcase
    endtask

    // Sample results first, then the request taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            reads_checked++;
            if (c_reads_due.size() == 0)
            begin
                $display("%0t: unexpected C read result row %0d col %0d value %h",
                         $time, row_res, col_res, value_res);
                mismatches++;
            end
            else
            begin
                due = c_reads_due.pop_front();
                if (row_res !== due.row || col_res !== due.col || value_res !== due.value)
                begin
                    $display("%0t: C read mismatch, expected row %0d col %0d value %h,",
                             $time, due.row, due.col, due.value);
                    $display("    got row %0d col %0d value %h",
                             row_res, col_res, value_res);
                    mismatches++;
                end
            end
        end
        req_taken = rst_n && in_valid && !in_stall;
        if (req_taken)
        begin
            mac_copy_apply({op, row, col, value});
            requests_accepted++;
        end
    end

    // Hold a stalled request; otherwise send in bursts with gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                next_req = request_queue.pop_front();
                burst_left--;
                in_valid <= 1'b1;
                op <= next_req.op;
                row <= next_req.row;
                col <= next_req.col;
                value <= next_req.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 40);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return VAL_W'(int'($urandom_range(0, 16)) - 8);
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_index(input int dim);
        if (dim == 0 || $urandom_range(0, 5) == 0)
            return $urandom_range(0, MAX_DIM - 1);
        return $urandom_range(0, dim - 1);
    endfunction

    function automatic bit [CFG_W-1:0] pick_dim();
        return ($urandom_range(0, 9) == 0) ? 5'd0 : CFG_W'($urandom_range(1, 8));
    endfunction

    task automatic push_request(input logic [OP_W-1:0] r_op, input int r_row, input int r_col,
                                input logic [VAL_W-1:0] r_val);
        mac_request_t req;
        req.op = r_op;
        req.row = r_row[IDX_W-1:0];
        req.col = r_col[IDX_W-1:0];
        req.value = r_val;
        if (r_op == OP_LOAD_A)
            a_loaded[{req.row, req.col}] = 1'b1;
        if (r_op == OP_LOAD_B)
            b_loaded[{req.row, req.col}] = 1'b1;
        if (r_op <= OP_READ_C)
            useful_items++;
        request_queue.push_back(req);
        requests_queued++;
    endtask

    // Load any A or B element the compute would read before it was ever written, then queue the compute.
    task automatic queue_compute();
        int n;
        int l;
        int m;
        n = eff_dim(cur_rows);
        l = eff_dim(cur_inner);
        m = eff_dim(cur_cols);
        for (int i = 0; i < n; i++)
            for (int k = 0; k < l; k++)
                if (!a_loaded[i*MAX_DIM + k])
                    push_request(OP_LOAD_A, i, k, rand_value());
        for (int k = 0; k < l; k++)
            for (int j = 0; j < m; j++)
                if (!b_loaded[k*MAX_DIM + j])
                    push_request(OP_LOAD_B, k, j, rand_value());
        push_request(OP_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
    endtask

    task automatic write_config(input bit [CFG_W-1:0] r, input bit [CFG_W-1:0] il,
                                input bit [CFG_W-1:0] c, input bit a);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ROWS_A;
        cfg_data <= r;
        cur_rows = r;
        @(negedge clk);
        cfg_index <= CFG_INNER_LEN;
        cfg_data <= il;
        cur_inner = il;
        @(negedge clk);
        cfg_index <= CFG_COLS_B;
        cfg_data <= c;
        cur_cols = c;
        @(negedge clk);
        cfg_index <= CFG_ACCUMULATE;
        cfg_data <= {{(CFG_W-1){1'b0}}, a};
        cur_acc = a;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Wait for every request and read, then let a last compute run out.
    task automatic settle();
        int n;
        int l;
        int m;
        n = eff_dim(cur_rows);
        l = eff_dim(cur_inner);
        m = eff_dim(cur_cols);
        while (requests_accepted != requests_queued || c_reads_due.size() != 0)
            @(posedge clk);
        repeat (n * m * ((l > 0) ? l : 1) + 16) @(posedge clk);
    endtask

    task automatic random_phase();
        int n;
        int l;
        int m;
        int target;
        logic [OP_W-1:0] noise_op;
        n = eff_dim(cur_rows);
        l = eff_dim(cur_inner);
        m = eff_dim(cur_cols);
        target = useful_items + $urandom_range(15, 25);
        while (useful_items < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 1))
                        push_request(OP_LOAD_A, pick_index(n), pick_index(l), rand_value());
                    else
                        push_request(OP_LOAD_B, pick_index(l), pick_index(m), rand_value());
                end
                if ($urandom_range(0, 2) == 0)
                    push_request(OP_LOAD_C, pick_index(n), pick_index(m), rand_value());
                queue_compute();
                repeat ($urandom_range(1, 5))
                    push_request(OP_READ_C, pick_index(n), pick_index(m), rand_value());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    noise_op = OP_W'($urandom_range(OP_LOAD_A, OP_UNUSED_HI));
                    if (noise_op == OP_COMPUTE)
                        queue_compute();
                    else
                        push_request(noise_op, $urandom_range(0, 15), $urandom_range(0, 15),
                                     rand_value());
                end
            end
        end
    endtask

    initial
    begin
        int directed_items;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Extremes, preloaded C outside the region, spare op codes, clear-mode compute.
        write_config(5'd2, 5'd2, 5'd2, 1'b0);
        push_request(OP_READ_C, 15, 15, 32'h0);
        push_request(OP_LOAD_C, 15, 0, 32'h7fff_ffff);
        push_request(OP_LOAD_C, 0, 15, 32'h8000_0000);
        push_request(OP_LOAD_C, 1, 1, 32'd5);
        push_request(OP_LOAD_A, 0, 0, 32'hffff_ffff);
        push_request(OP_LOAD_A, 0, 1, 32'h8000_0000);
        push_request(OP_LOAD_A, 1, 0, 32'h7fff_ffff);
        push_request(OP_LOAD_A, 1, 1, 32'd3);
        push_request(OP_LOAD_B, 0, 0, 32'h7fff_ffff);
        push_request(OP_LOAD_B, 0, 1, 32'hffff_ffff);
        push_request(OP_LOAD_B, 1, 0, 32'h8000_0000);
        push_request(OP_LOAD_B, 1, 1, 32'd2);
        push_request(OP_UNUSED_LO, 15, 15, 32'hffff_ffff);
        push_request(OP_UNUSED_MID, 0, 0, 32'h0);
        push_request(OP_UNUSED_HI, 15, 0, 32'h8000_0000);
        queue_compute();
        push_request(OP_READ_C, 0, 0, 32'h0);
        push_request(OP_READ_C, 1, 1, 32'h0);
        push_request(OP_READ_C, 15, 0, 32'h0);
        push_request(OP_READ_C, 0, 15, 32'h0);
        settle();

        write_config(5'd2, 5'd2, 5'd2, 1'b1);
        queue_compute();
        push_request(OP_READ_C, 1, 0, 32'h0);
        settle();

        // Empty inner loop: clear mode zeroes the region.
        write_config(5'd2, 5'd0, 5'd2, 1'b0);
        queue_compute();
        push_request(OP_READ_C, 1, 1, 32'h0);
        settle();

        // No rows: C stays as it is.
        write_config(5'd0, 5'd2, 5'd2, 1'b0);
        push_request(OP_LOAD_C, 0, 0, 32'h1234_5678);
        queue_compute();
        push_request(OP_READ_C, 0, 0, 32'h0);
        settle();
        directed_items = useful_items;

        write_config(5'd1, 5'd1, 5'd1, 1'b0);
        random_phase();
        settle();
        write_config(5'd16, 5'd16, 5'd16, 1'b1);
        random_phase();
        settle();
        write_config(5'd31, 5'd17, 5'd24, 1'b0);
        random_phase();
        settle();
        write_config(5'd0, 5'd5, 5'd3, 1'b1);
        random_phase();
        settle();
        write_config(5'd4, 5'd0, 5'd4, 1'b1);
        random_phase();
        settle();
        while (useful_items < directed_items + 600)
        begin
            write_config(pick_dim(), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
            random_phase();
            settle();
        end

        $display("Covered %0d requests (%0d computes) over %0d size and mode settings",
                 requests_accepted, computes_seen, settings_applied);
        $display("Checked %0d C reads, %0d mismatches", reads_checked, mismatches);
        if (mismatches == 0)
            $display("PASS integer_matrix_multiply_accumulate_core");
        else
            $display("FAIL integer_matrix_multiply_accumulate_core");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/imac_pkg.sv
rtl/integer_matrix_multiply_accumulate_core.sv
rtl/imac_checker.sv
tb/sv/integer_matrix_multiply_accumulate_core_test.sv
